// ===== hw/rtl/rgt_pkg.sv =====
// Shared constants for the replay guard table.
package rgt_pkg;

  localparam int SenderCountDef = 16;
  localparam int VerbCountDef   = 16;

  localparam int MarkW = 31;
  localparam int CntW  = 32;
  localparam int SeqW  = 32;
  localparam int IdW   = 4;

  localparam logic REQ_CHECK = 1'b0;
  localparam logic REQ_STAMP = 1'b1;

  localparam logic [MarkW-1:0] MARK_MAX = {MarkW{1'b1}};
  localparam logic [CntW-1:0]  CNT_MAX  = {CntW{1'b1}};

endpackage

// ===== hw/rtl/replay_guard_table.sv =====
// Replay guard table: per sender/verb high-water marks, refusal tallies and stamp counter.
// A request is taken with the mark RAM read; the execute state writes back, registers the
// result and strobes done_o. Requests do not overlap: busy is high while one executes.
// Reset: a clearing pass over all SENDER_COUNT*VERB_COUNT mark entries zeroes both RAMs;
// busy is high for it. Total count and stamp clear at once. The receiver cannot stall.
module replay_guard_table
  import rgt_pkg::*;
#(
  parameter int SENDER_COUNT = SenderCountDef,
  parameter int VERB_COUNT   = VerbCountDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type_i,
  input  logic [IdW-1:0]         sender_id_i,
  input  logic [IdW-1:0]         verb_id_i,
  input  logic signed [SeqW-1:0] seq_number_i,
  output logic                   done_o,
  output logic                   accepted_o,
  output logic [MarkW-1:0]       mark_value_o,
  output logic [CntW-1:0]        verb_refusal_count_o,
  output logic [CntW-1:0]        total_refusal_count_o,
  output logic [MarkW-1:0]       stamp_value_o
);

  localparam int PairDepth = SENDER_COUNT * VERB_COUNT;
  localparam int PairAw    = (PairDepth > 1) ? $clog2(PairDepth) : 1;
  localparam int VerbAw    = (VERB_COUNT > 1) ? $clog2(VERB_COUNT) : 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [PairAw-1:0] clr_q, clr_d;
  logic              clr_last;

  logic              type_q;
  logic              seq_pos_q;
  logic [MarkW-1:0]  seq_q;
  logic [PairAw-1:0] pidx_q;
  logic [VerbAw-1:0] vidx_q;
  logic              pair_ok_q, verb_ok_q;

  logic [CntW-1:0]   total_q, total_d;
  logic [MarkW-1:0]  stamp_q, stamp_d;

  logic              sender_ok, verb_ok;
  logic [PairAw-1:0] pidx_in;
  logic [VerbAw-1:0] vidx_in;
  logic              accept;

  logic              mark_we, verb_we;
  logic [PairAw-1:0] mark_waddr;
  logic [VerbAw-1:0] verb_waddr;
  logic [MarkW-1:0]  mark_wdata, mark_rdata;
  logic [CntW-1:0]   verb_wdata, verb_rdata;

  logic              fresh, refused;
  logic [CntW-1:0]   verb_inc;

  logic              done_q;
  logic              accepted_q;
  logic [MarkW-1:0]  mark_out_q;
  logic [CntW-1:0]   verb_out_q;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign sender_ok = (32'(sender_id_i) < 32'(SENDER_COUNT));
  assign verb_ok   = (32'(verb_id_i) < 32'(VERB_COUNT));
  assign pidx_in   = (sender_ok && verb_ok) ?
                     PairAw'(32'(sender_id_i) * 32'(VERB_COUNT) + 32'(verb_id_i)) : '0;
  assign vidx_in   = verb_ok ? VerbAw'(verb_id_i) : '0;

  assign clr_last = (32'(clr_q) == 32'(PairDepth - 1));

  // Update logic, valid in the execute cycle
  assign fresh    = (type_q == REQ_CHECK) && pair_ok_q && seq_pos_q && (seq_q > mark_rdata);
  assign refused  = (type_q == REQ_CHECK) && !fresh;
  assign verb_inc = (verb_rdata == CNT_MAX) ? verb_rdata : verb_rdata + 1'b1;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    total_d    = total_q;
    stamp_d    = stamp_q;
    mark_we    = 1'b0;
    mark_waddr = pidx_q;
    mark_wdata = seq_q;
    verb_we    = 1'b0;
    verb_waddr = vidx_q;
    verb_wdata = verb_inc;
    case (state_q)
      ST_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_q;
        mark_wdata = '0;
        verb_we    = (32'(clr_q) < 32'(VERB_COUNT));
        verb_waddr = VerbAw'(clr_q);
        verb_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        if (type_q == REQ_STAMP) begin
          if (stamp_q != MARK_MAX) begin
            stamp_d = stamp_q + 1'b1;
          end
        end else if (fresh) begin
          mark_we = 1'b1;
        end else begin
          verb_we = verb_ok_q;
          if (total_q != CNT_MAX) begin
            total_d = total_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      total_q <= '0;
      stamp_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      total_q <= total_d;
      stamp_q <= stamp_d;
      done_q  <= (state_q == ST_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q    <= req_type_i;
      seq_pos_q <= !seq_number_i[SeqW-1] && (seq_number_i != '0);
      seq_q     <= seq_number_i[MarkW-1:0];
      pidx_q    <= pidx_in;
      vidx_q    <= vidx_in;
      pair_ok_q <= sender_ok && verb_ok;
      verb_ok_q <= verb_ok;
    end
    if (state_q == ST_EXEC) begin
      accepted_q <= fresh;
      mark_out_q <= !pair_ok_q ? '0 : (fresh ? seq_q : mark_rdata);
      verb_out_q <= !verb_ok_q ? '0 : (refused ? verb_inc : verb_rdata);
    end
  end

  rgt_ram #(
    .Width (MarkW),
    .Depth (PairDepth),
    .Aw    (PairAw)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (pidx_in),
    .rdata_o (mark_rdata)
  );

  rgt_ram #(
    .Width (CntW),
    .Depth (VERB_COUNT),
    .Aw    (VerbAw)
  ) u_verb_ram (
    .clk_i   (clk_i),
    .we_i    (verb_we),
    .waddr_i (verb_waddr),
    .wdata_i (verb_wdata),
    .raddr_i (vidx_in),
    .rdata_o (verb_rdata)
  );

  assign done_o                = done_q;
  assign accepted_o            = accepted_q;
  assign mark_value_o          = mark_out_q;
  assign verb_refusal_count_o  = verb_out_q;
  assign total_refusal_count_o = total_q;
  assign stamp_value_o         = stamp_q;

endmodule

// ===== hw/rtl/rgt_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module rgt_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  parameter int Aw    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/replay_guard_table_test.sv =====
// Self-checking testbench for the replay guard table: directed table, then random requests.
`timescale 1ns / 100ps

module replay_guard_table_test;
  import rgt_pkg::*;

  localparam int PairDepth     = SenderCountDef * VerbCountDef;
  localparam int ItemsPerPhase = 340;
  localparam int CycleLimit    = 200000;

  typedef struct packed {
    logic           req_type;
    logic [IdW-1:0] sender;
    logic [IdW-1:0] verb;
    logic [SeqW-1:0] seq;
  } guard_req_t;

  typedef struct packed {
    logic             accepted;
    logic [MarkW-1:0] mark;
    logic [CntW-1:0]  verb_cnt;
    logic [CntW-1:0]  total_cnt;
    logic [MarkW-1:0] stamp;
  } guard_resp_t;

  typedef struct {
    guard_req_t  rq;
    bit          typed;
    guard_resp_t resp;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic                   req_type_i;
  logic [IdW-1:0]         sender_id_i;
  logic [IdW-1:0]         verb_id_i;
  logic signed [SeqW-1:0] seq_number_i;
  logic                   done_o;
  logic                   accepted_o;
  logic [MarkW-1:0]       mark_value_o;
  logic [CntW-1:0]        verb_refusal_count_o;
  logic [CntW-1:0]        total_refusal_count_o;
  logic [MarkW-1:0]       stamp_value_o;

  // predictor state
  logic [MarkW-1:0] pair_mark [PairDepth];
  logic [CntW-1:0]  refusals_by_verb [VerbCountDef];
  logic [CntW-1:0]  refused_sum;
  logic [MarkW-1:0] stamp_ctr;

  guard_resp_t pending_verdicts[$];
  stim_row_t   directed_rows[$];

  int error_count;
  int results_checked;
  int n_requests;
  int n_fresh;
  int n_refused;
  int n_stamps;
  int idle_pct;
  int cycles;

  replay_guard_table i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .req_type_i           (req_type_i),
    .sender_id_i          (sender_id_i),
    .verb_id_i            (verb_id_i),
    .seq_number_i         (seq_number_i),
    .done_o               (done_o),
    .accepted_o           (accepted_o),
    .mark_value_o         (mark_value_o),
    .verb_refusal_count_o (verb_refusal_count_o),
    .total_refusal_count_o(total_refusal_count_o),
    .stamp_value_o        (stamp_value_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_verdicts.size());
      $display("replay_guard_table_test: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at result %0d: %s got 0x%08h want 0x%08h", results_checked, what, got,
             want);
    error_count++;
  endtask

  function automatic guard_resp_t apply_guard(guard_req_t rq);
    guard_resp_t r;
    bit          s_ok;
    bit          v_ok;
    int          idx;
    s_ok = rq.sender < SenderCountDef;
    v_ok = rq.verb < VerbCountDef;
    idx  = (s_ok && v_ok) ? int'(rq.sender) * VerbCountDef + int'(rq.verb) : 0;
    r.accepted = 1'b0;
    if (rq.req_type == REQ_STAMP) begin
      if (stamp_ctr != MARK_MAX) stamp_ctr++;
      n_stamps++;
    end else if (s_ok && v_ok && !rq.seq[SeqW-1] && rq.seq != '0 &&
                 rq.seq[MarkW-1:0] > pair_mark[idx]) begin
      pair_mark[idx] = rq.seq[MarkW-1:0];
      r.accepted = 1'b1;
      n_fresh++;
    end else begin
      if (v_ok && refusals_by_verb[rq.verb] != CNT_MAX) refusals_by_verb[rq.verb]++;
      if (refused_sum != CNT_MAX) refused_sum++;
      n_refused++;
    end
    r.mark      = (s_ok && v_ok) ? pair_mark[idx] : '0;
    r.verb_cnt  = v_ok ? refusals_by_verb[rq.verb] : '0;
    r.total_cnt = refused_sum;
    r.stamp     = stamp_ctr;
    return r;
  endfunction

  // entered at a falling edge, returns at a falling edge
  task automatic issue_request(guard_req_t rq, bit typed, guard_resp_t typed_resp);
    guard_resp_t predicted;
    start        <= 1'b1;
    req_type_i   <= rq.req_type;
    sender_id_i  <= rq.sender;
    verb_id_i    <= rq.verb;
    seq_number_i <= rq.seq;
    do @(posedge clk_i); while (busy);
    predicted = apply_guard(rq);
    pending_verdicts.push_back(typed ? typed_resp : predicted);
    n_requests++;
    @(negedge clk_i);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic add_row(logic rt, int s, int v, logic [31:0] seq, bit typed, logic acc,
                         logic [30:0] mk, logic [31:0] vc, logic [31:0] tot, logic [30:0] st);
    stim_row_t row;
    row.rq    = '{req_type: rt, sender: IdW'(s), verb: IdW'(v), seq: seq};
    row.typed = typed;
    row.resp  = '{accepted: acc, mark: mk, verb_cnt: vc, total_cnt: tot, stamp: st};
    directed_rows.push_back(row);
  endtask

  always @(posedge clk_i) begin : check_results
    guard_resp_t want;
    if (rst_ni && done_o) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result, mark", 32'(mark_value_o), '0);
      end else begin
        want = pending_verdicts.pop_front();
        if (accepted_o !== want.accepted)
          report_mismatch("accepted", 32'(accepted_o), 32'(want.accepted));
        if (mark_value_o !== want.mark)
          report_mismatch("mark_value", 32'(mark_value_o), 32'(want.mark));
        if (verb_refusal_count_o !== want.verb_cnt)
          report_mismatch("verb_refusal_count", verb_refusal_count_o, want.verb_cnt);
        if (total_refusal_count_o !== want.total_cnt)
          report_mismatch("total_refusal_count", total_refusal_count_o, want.total_cnt);
        if (stamp_value_o !== want.stamp)
          report_mismatch("stamp_value", 32'(stamp_value_o), 32'(want.stamp));
      end
      results_checked++;
    end
  end

  initial begin
    guard_req_t       rq;
    guard_resp_t      no_resp;
    logic [MarkW-1:0] cur;
    int               roll;
    int               drain;

    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_type_i   = REQ_CHECK;
    sender_id_i  = '0;
    verb_id_i    = '0;
    seq_number_i = '0;
    no_resp      = '0;
    idle_pct     = 23;
    foreach (pair_mark[i]) pair_mark[i] = '0;
    foreach (refusals_by_verb[i]) refusals_by_verb[i] = '0;
    refused_sum = '0;
    stamp_ctr   = '0;

    // cold start, non-positive sequences, equal and maximum marks
    add_row(REQ_STAMP, 0, 0, 32'h0000_0000, 1, 0, 31'h0, 0, 0, 1);
    add_row(REQ_CHECK, 0, 0, 32'h0000_0000, 1, 0, 31'h0, 1, 1, 1);
    add_row(REQ_CHECK, 0, 0, 32'hFFFF_FFFF, 1, 0, 31'h0, 2, 2, 1);
    add_row(REQ_CHECK, 0, 0, 32'h8000_0000, 1, 0, 31'h0, 3, 3, 1);
    add_row(REQ_CHECK, 0, 0, 32'h0000_0001, 1, 1, 31'h1, 3, 3, 1);
    add_row(REQ_CHECK, 0, 0, 32'h0000_0001, 1, 0, 31'h1, 4, 4, 1);
    add_row(REQ_CHECK, 15, 15, 32'h7FFF_FFFF, 1, 1, 31'h7FFF_FFFF, 0, 4, 1);
    add_row(REQ_CHECK, 15, 15, 32'h7FFF_FFFF, 1, 0, 31'h7FFF_FFFF, 1, 5, 1);
    add_row(REQ_STAMP, 15, 15, 32'h1234_5678, 1, 0, 31'h7FFF_FFFF, 1, 5, 2);
    add_row(REQ_CHECK, 15, 15, 32'hFFFF_FFFF, 1, 0, 31'h7FFF_FFFF, 2, 6, 2);
    add_row(REQ_CHECK, 0, 0, 32'h7FFF_FFFE, 0, 0, 0, 0, 0, 0);
    add_row(REQ_CHECK, 0, 0, 32'h0000_0005, 0, 0, 0, 0, 0, 0);
    add_row(REQ_CHECK, 3, 0, 32'h0000_0064, 0, 0, 0, 0, 0, 0);
    add_row(REQ_CHECK, 0, 3, 32'h0000_0002, 0, 0, 0, 0, 0, 0);
    add_row(REQ_STAMP, 7, 8, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
    add_row(REQ_STAMP, 8, 7, 32'h0000_0000, 0, 0, 0, 0, 0, 0);
    add_row(REQ_CHECK, 5, 9, 32'h5555_5555, 0, 0, 0, 0, 0, 0);
    add_row(REQ_CHECK, 5, 9, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0);
    add_row(REQ_CHECK, 10, 6, 32'h2AAA_AAAA, 0, 0, 0, 0, 0, 0);
    add_row(REQ_CHECK, 10, 6, 32'h2AAA_AAAB, 0, 0, 0, 0, 0, 0);
    add_row(REQ_CHECK, 10, 6, 32'h2AAA_AAAA, 0, 0, 0, 0, 0, 0);
    add_row(REQ_STAMP, 0, 15, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      issue_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].resp);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 23 : (ph == 1) ? 78 : 0;
      for (int k = 0; k < ItemsPerPhase; k++) begin
        roll        = $urandom_range(0, 99);
        rq.req_type = REQ_CHECK;
        rq.sender   = IdW'($urandom_range(0, SenderCountDef - 1));
        rq.verb     = IdW'($urandom_range(0, VerbCountDef - 1));
        rq.seq      = $urandom;
        cur = pair_mark[int'(rq.sender) * VerbCountDef + int'(rq.verb)];
        if (roll < 4) begin
          rq.seq[SeqW-1] = 1'b0;
        end else if (roll < 55) begin
          if (cur > MARK_MAX - 31'd32) rq.seq = {1'b0, MARK_MAX};
          else rq.seq = {1'b0, cur + 31'($urandom_range(1, 32))};
        end else if (roll < 68) begin
          rq.seq = {1'b0, cur - 31'($urandom_range(0, (cur > 31'd8) ? 8 : int'(cur)))};
        end else if (roll < 77) begin
          case ($urandom_range(0, 2))
            0: rq.seq = '0;
            1: rq.seq[SeqW-1] = 1'b1;
            default: ;
          endcase
        end else begin
          rq.req_type = REQ_STAMP;
        end
        issue_request(rq, 1'b0, no_resp);
      end
    end
    start <= 1'b0;

    drain = 0;
    while (pending_verdicts.size() != 0 && drain < 1000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_verdicts.size() != 0) begin
      $display("%0d expected results never arrived", pending_verdicts.size());
      error_count++;
    end

    $display("%0d requests driven (%0d fresh checks, %0d refusals, %0d stamps)", n_requests,
             n_fresh, n_refused, n_stamps);
    $display("%0d results compared, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("replay_guard_table_test: PASS");
    end else begin
      $display("replay_guard_table_test: FAIL");
    end
    $finish;
  end

endmodule
